>>> design/r2pc_pkg.sv
// package for the rgb to pixel code block: sizes, request and register codes,
// and the structs that pass between its modules
// no dependencies
`default_nettype none

package r2pc_pkg;

    // palette store size and derived widths
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COLOR_W         = 24;
    localparam int DIST_W          = 18;

    // input request kinds (tuser)
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_PALETTE_MODE = 2'd0;
    localparam logic [1:0] CFG_RED_MASK     = 2'd1;
    localparam logic [1:0] CFG_GREEN_MASK   = 2'd2;
    localparam logic [1:0] CFG_BLUE_MASK    = 2'd3;

    // one configuration write transaction
    typedef struct packed {
        logic        en;
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

    // one palette entry write
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] data;
    } t_pal_wr;

endpackage

`default_nettype wire

>>> design/r2pc_pack.sv
// packed-mode conversion: channel mask registers, derived shift and loss per
// channel, and the combinational pack of one colour into a 32-bit word
// depends on r2pc_pkg
`default_nettype none

module r2pc_pack
    import r2pc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg_wr     i_cfg_wr,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic [31:0]      o_code,
    output logic             o_busy
);

    // position of the lowest set bit of a mask
    function automatic logic [4:0] f_low_pos(input logic [31:0] m);
        logic [31:0] iso;
        logic [4:0]  p;
        iso = m & (~m + 32'd1);
        p   = '0;
        for (int k = 0; k < 32; k++) begin
            if (iso[k]) p = p | 5'(k);
        end
        return p;
    endfunction

    // low bits dropped: 8 minus the run length, clamped at zero
    function automatic logic [3:0] f_loss(input logic [31:0] m, input logic [4:0] p);
        logic [31:0] s;
        logic [3:0]  run;
        logic        stop;
        s    = m >> p;
        run  = '0;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!stop && s[k]) run = run + 4'd1;
            else stop = 1'b1;
        end
        return 4'd8 - run;
    endfunction

    // one channel into its field
    function automatic logic [31:0] f_pack(input logic [7:0] c, input logic [31:0] m,
                                           input logic [4:0] p, input logic [3:0] l);
        logic [7:0] kept;
        kept = c >> l;
        return (32'(kept) << p) & m;
    endfunction

    logic [31:0] r_mask [3];
    logic [4:0]  r_pos  [3];
    logic [3:0]  r_loss [3];
    logic        r_drv_pos;
    logic        r_drv_loss;
    logic        mask_wr;

    assign mask_wr = i_cfg_wr.en && (i_cfg_wr.index != CFG_PALETTE_MODE);

    // mask registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= '0;
            r_mask[1] <= '0;
            r_mask[2] <= '0;
        end else if (i_cfg_wr.en) begin
            unique case (i_cfg_wr.index)
                CFG_RED_MASK:     r_mask[0] <= i_cfg_wr.data;
                CFG_GREEN_MASK:   r_mask[1] <= i_cfg_wr.data;
                CFG_BLUE_MASK:    r_mask[2] <= i_cfg_wr.data;
                default: ;
            endcase
        end
    end

    // two-step derivation after a mask write: position, then loss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_pos  <= 1'b0;
            r_drv_loss <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_pos[c]  <= '0;
                r_loss[c] <= 4'd8;
            end
        end else begin
            r_drv_pos  <= mask_wr;
            r_drv_loss <= r_drv_pos;
            for (int c = 0; c < 3; c++) begin
                if (r_drv_pos)  r_pos[c]  <= f_low_pos(r_mask[c]);
                if (r_drv_loss) r_loss[c] <= f_loss(r_mask[c], r_pos[c]);
            end
        end
    end

    assign o_busy = r_drv_pos || r_drv_loss;

    // combine the three fields
    assign o_code = f_pack(i_red,   r_mask[0], r_pos[0], r_loss[0])
                  | f_pack(i_green, r_mask[1], r_pos[1], r_loss[1])
                  | f_pack(i_blue,  r_mask[2], r_pos[2], r_loss[2]);

endmodule

`default_nettype wire

>>> design/r2pc_palette.sv
// palette store and nearest-entry scan: one memory read per cycle, a distance
// stage and a running best compare
// depends on r2pc_pkg
`default_nettype none

module r2pc_palette
    import r2pc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_pal_wr          i_wr,
    input  wire logic             i_start,
    input  wire logic [7:0]       i_red,
    input  wire logic [7:0]       i_green,
    input  wire logic [7:0]       i_blue,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_index
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    function automatic logic [15:0] f_sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    logic [COLOR_W-1:0] r_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] r_rdata;
    logic               r_busy;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_d_vld;
    logic               r_d_last;
    logic [IDX_W-1:0]   r_d_idx;
    logic [DIST_W-1:0]  r_dist;
    logic               r_have;
    logic [DIST_W-1:0]  r_best_d;
    logic [IDX_W-1:0]   r_best_i;
    logic               r_done;
    logic [DIST_W-1:0]  n_dist;

    // palette memory: writes only arrive while no scan runs
    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
        if (r_busy)  r_rdata <= r_mem[r_cnt];
    end

    // read address sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld  <= r_busy;
            r_rd_last <= r_busy && (r_cnt == LAST_IDX);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_IDX) r_busy <= 1'b0;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
    end

    // squared distance of the entry just read
    assign n_dist = 18'(f_sq_diff(i_red,   r_rdata[23:16]))
                  + 18'(f_sq_diff(i_green, r_rdata[15:8]))
                  + 18'(f_sq_diff(i_blue,  r_rdata[7:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld  <= 1'b0;
            r_d_last <= 1'b0;
        end else begin
            r_d_vld  <= r_rd_vld;
            r_d_last <= r_rd_vld && r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist  <= n_dist;
        r_d_idx <= r_rd_idx;
    end

    // running best; strict compare keeps the first of equal distances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_d_vld && r_d_last;
            if (i_start)      r_have <= 1'b0;
            else if (r_d_vld) r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_vld && (!r_have || (r_dist < r_best_d))) begin
            r_best_d <= r_dist;
            r_best_i <= r_d_idx;
        end
    end

    assign o_done  = r_done;
    assign o_index = r_best_i;

endmodule

`default_nettype wire

>>> design/rgb_to_pixel_code_core.sv
// rgb to pixel code top level: stream ports, request control, output register
// depends on r2pc_pkg, r2pc_pack, r2pc_palette
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata: entry, r, g, b; tuser: kind
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata: pixel_code
//  cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// a palette write completes on acceptance; a packed conversion passes through the PACK and
// DONE states to the output register; a palette conversion waits in the SCAN state while every
// entry is read through the single read port of the palette memory.
// a mask write holds s_axis_tready low while shift and loss are derived.
// reset clears control and mask state; datapath and palette memory are undefined until written.
// a result stalled in the output register holds the next finished result, and the input with it.
`default_nettype none

module rgb_to_pixel_code_core
    import r2pc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // entry_index[7:0], red, green, blue
    input  wire logic [0:0]  s_axis_tuser,   // req_type
    // stream output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // pixel_code
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PACK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_mode;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic [31:0]      r_result;
    logic             r_out_valid;
    logic [31:0]      r_out_data;

    logic             in_acc;
    logic             is_conv;
    logic [7:0]       in_index;
    logic             out_load;
    t_cfg_wr          cfg_wr;
    t_pal_wr          pal_wr;
    logic [31:0]      pack_code;
    logic             pack_busy;
    logic             pal_done;
    logic [IDX_W-1:0] pal_index;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr.en    = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign s_axis_tready = (r_state == ST_IDLE) && !pack_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_conv       = (s_axis_tuser[0] == REQ_CONVERT);
    assign in_index      = s_axis_tdata[7:0];

    // palette write, out-of-range entries dropped; entry holds red, green, blue from the top
    assign pal_wr.en   = in_acc && (s_axis_tuser[0] == REQ_WRITE)
                      && ({1'b0, in_index} < 9'(PALETTE_ENTRIES));
    assign pal_wr.addr = in_index[IDX_W-1:0];
    assign pal_wr.data = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};

    r2pc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_wr(cfg_wr),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_code  (pack_code),
        .o_busy  (pack_busy)
    );

    r2pc_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (pal_wr),
        .i_start (in_acc && is_conv && r_mode),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_done  (pal_done),
        .o_index (pal_index)
    );

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (cfg_wr.en && (cfg_wr.index == CFG_PALETTE_MODE)) begin
            r_mode <= cfg_wr.data[0];
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // request sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_conv) n_state = r_mode ? ST_SCAN : ST_PACK;
            end
            ST_PACK: n_state = ST_DONE;
            ST_SCAN: begin
                if (pal_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // colour and result holding registers
    always_ff @(posedge i_clk) begin
        if (in_acc && is_conv) begin
            r_red   <= s_axis_tdata[15:8];
            r_green <= s_axis_tdata[23:16];
            r_blue  <= s_axis_tdata[31:24];
        end
        if (r_state == ST_PACK)                 r_result <= pack_code;
        else if (r_state == ST_SCAN && pal_done) r_result <= 32'(pal_index);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= r_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // scan completion only while a palette conversion is pending
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_done |-> (r_state == ST_SCAN))
        else $error("palette scan finished outside a palette conversion");

    // a finished result moves into a free output register and frees the input
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished result not delivered to output register");

    // input held off while mask shift and loss are derived
    a_mask_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index != CFG_PALETTE_MODE)) |=> !s_axis_tready)
        else $error("input accepted during mask derivation");

endmodule

`default_nettype wire
